@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dol_pkg.sv @@
// ----------------------------------------------------------------------------
// dol_pkg
// Types and constants for the DHCP option locator and its checker.
// ----------------------------------------------------------------------------
package dol_pkg;

	// Message geometry.
	localparam int MAX_MESSAGE_BYTES_DEF = 1024;
	localparam int FIXED_HEADER_BYTES    = 236;
	localparam int COOKIE_BYTES          = 4;
	localparam int OPTION_OVERHEAD       = 2;
	localparam int MIN_VALUE_OFFSET      = COOKIE_BYTES + OPTION_OVERHEAD;

	// Field widths.
	localparam int OFFSET_W = 10;
	localparam int BYTE_W   = 8;

	// Option codes.
	localparam logic [BYTE_W-1:0] CODE_PAD      = 8'd0;
	localparam logic [BYTE_W-1:0] CODE_END      = 8'd255;
	localparam logic [BYTE_W-1:0] CODE_MSG_TYPE = 8'd53;

	// Input item: one message byte.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} dol_in_t;

	// Result item: one per message.
	typedef struct packed {
		logic                cookie_valid;
		logic                option_found;
		logic [OFFSET_W-1:0] value_offset;
		logic [BYTE_W-1:0]   value_length;
		logic                type_found;
		logic [BYTE_W-1:0]   message_type;
	} dol_out_t;

	// Magic cookie 99.130.83.99, indexed by byte within the cookie.
	function automatic logic [BYTE_W-1:0] cookie_byte(input logic [1:0] idx);
		logic [BYTE_W-1:0] b;
		unique case (idx)
			2'd0: b = 8'd99;
			2'd1: b = 8'd130;
			2'd2: b = 8'd83;
			2'd3: b = 8'd99;
			default: b = 8'd99;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/dhcp_option_locator.sv @@
// ----------------------------------------------------------------------------
// dhcp_option_locator
// Streams a DHCP message byte by byte, checks the magic cookie, walks the
// option list and reports where the wanted option's value lies, together
// with the message type, once per message on its last byte.
// ----------------------------------------------------------------------------
//  Channel   Signals                      Moves
//  in        in_valid/in_stall/in_data    one message byte per transfer
//  out       out_valid/out_stall/out_data one result per message
//  cfg       cfg_we/cfg_wdata             wanted option code (reset 53)
//
// One byte is taken every cycle while in_stall is low; each byte is held in
// the input register, and the parser state and the result register both
// update as it leaves it; the last byte's leaving loads the result.
// Reset clears the parser and sets the wanted code to 53; no clearing pass.
// A held result only stalls the input when a further last byte waits in the
// input register behind it.
module dhcp_option_locator #(
	parameter int MAX_MESSAGE_BYTES = dol_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  dol_pkg::dol_in_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output dol_pkg::dol_out_t out_data,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata
);
	import dol_pkg::*;

	localparam int POS_W   = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int OFF_W   = (POS_W > OFFSET_W ? POS_W : OFFSET_W) + 1;
	localparam int OFF_MAX = (1 << OFFSET_W) - 1;

	// Parser phases.
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_CODE   = 3'd1;
	localparam logic [2:0] PH_LEN    = 3'd2;
	localparam logic [2:0] PH_VALUE  = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic [BYTE_W-1:0] wanted_q;

	logic    valid_s1;
	dol_in_t data_s1;

	logic [POS_W-1:0]    pos_q, pos_d;
	logic [2:0]          phase_q, phase_d;
	logic [BYTE_W-1:0]   skip_q, skip_d;
	logic                cookie_good_q, cookie_good_d;
	logic                match_seen_q, match_seen_d;
	logic [OFFSET_W-1:0] match_offset_q, match_offset_d;
	logic [BYTE_W-1:0]   match_length_q, match_length_d;
	logic                type_seen_q, type_seen_d;
	logic [BYTE_W-1:0]   type_value_q, type_value_d;
	logic                match_pending_q, match_pending_d;
	logic                type_pending_q, type_pending_d;

	logic     out_valid_q;
	dol_out_t out_data_q;

	logic              advance;
	logic              out_free;
	logic [BYTE_W-1:0] b;
	logic [OFF_W-1:0]  off;
	logic              res_valid, res_found, res_tfound;

	assign b        = data_s1.data_byte;
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!data_s1.last_byte || out_free);
	assign in_stall = valid_s1 && !advance;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Value offset counted from the first cookie byte.
	assign off = OFF_W'(pos_q) + OFF_W'(OPTION_OVERHEAD) - OFF_W'(FIXED_HEADER_BYTES);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= CODE_MSG_TYPE;
		end else if (cfg_we) begin
			wanted_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Parser next state for the byte in the input register.
	always_comb begin
		pos_d           = pos_q;
		phase_d         = phase_q;
		skip_d          = skip_q;
		cookie_good_d   = cookie_good_q;
		match_seen_d    = match_seen_q;
		match_offset_d  = match_offset_q;
		match_length_d  = match_length_q;
		type_seen_d     = type_seen_q;
		type_value_d    = type_value_q;
		match_pending_d = match_pending_q;
		type_pending_d  = type_pending_q;
		if (pos_q < POS_W'(MAX_MESSAGE_BYTES)) begin
			pos_d = pos_q + POS_W'(1);
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q >= POS_W'(FIXED_HEADER_BYTES) &&
					    pos_q < POS_W'(FIXED_HEADER_BYTES + COOKIE_BYTES)) begin
						if (b != cookie_byte(pos_q[1:0])) begin
							cookie_good_d = 1'b0;
						end
						if (pos_q == POS_W'(FIXED_HEADER_BYTES + COOKIE_BYTES - 1)) begin
							phase_d = PH_CODE;
						end
					end
				end
				PH_CODE: begin
					if (b == CODE_END) begin
						phase_d = PH_DONE;
					end else if (b != CODE_PAD) begin
						if (b == wanted_q && !match_seen_q) begin
							match_seen_d    = 1'b1;
							match_pending_d = 1'b1;
							match_offset_d  = (off > OFF_W'(OFF_MAX)) ?
								OFFSET_W'(OFF_MAX) : off[OFFSET_W-1:0];
						end
						if (b == CODE_MSG_TYPE && !type_seen_q) begin
							type_seen_d    = 1'b1;
							type_pending_d = 1'b1;
						end
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					if (match_pending_q) begin
						match_length_d  = b;
						match_pending_d = 1'b0;
					end
					if (b == '0) begin
						type_pending_d = 1'b0;
						phase_d        = PH_CODE;
					end else begin
						skip_d  = b;
						phase_d = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (type_pending_q) begin
						type_value_d   = b;
						type_pending_d = 1'b0;
					end
					// The count is never zero on entry to this phase.
					skip_d = skip_q - BYTE_W'(1);
					if (skip_q == BYTE_W'(1)) begin
						phase_d = PH_CODE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result fields, taken from the state after the last byte.
	assign res_valid  = cookie_good_d && (phase_d != PH_HEADER);
	assign res_found  = res_valid && match_seen_d;
	assign res_tfound = res_valid && type_seen_d;

	// Parser state; a last byte clears it for the next message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= '0;
			phase_q         <= PH_HEADER;
			skip_q          <= '0;
			cookie_good_q   <= 1'b1;
			match_seen_q    <= 1'b0;
			match_offset_q  <= '0;
			match_length_q  <= '0;
			type_seen_q     <= 1'b0;
			type_value_q    <= '0;
			match_pending_q <= 1'b0;
			type_pending_q  <= 1'b0;
		end else if (advance) begin
			if (data_s1.last_byte) begin
				pos_q           <= '0;
				phase_q         <= PH_HEADER;
				skip_q          <= '0;
				cookie_good_q   <= 1'b1;
				match_seen_q    <= 1'b0;
				match_offset_q  <= '0;
				match_length_q  <= '0;
				type_seen_q     <= 1'b0;
				type_value_q    <= '0;
				match_pending_q <= 1'b0;
				type_pending_q  <= 1'b0;
			end else begin
				pos_q           <= pos_d;
				phase_q         <= phase_d;
				skip_q          <= skip_d;
				cookie_good_q   <= cookie_good_d;
				match_seen_q    <= match_seen_d;
				match_offset_q  <= match_offset_d;
				match_length_q  <= match_length_d;
				type_seen_q     <= type_seen_d;
				type_value_q    <= type_value_d;
				match_pending_q <= match_pending_d;
				type_pending_q  <= type_pending_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && data_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && data_s1.last_byte) begin
			out_data_q.cookie_valid <= res_valid;
			out_data_q.option_found <= res_found;
			out_data_q.value_offset <= res_found ? match_offset_d : '0;
			out_data_q.value_length <= res_found ? match_length_d : '0;
			out_data_q.type_found   <= res_tfound;
			out_data_q.message_type <= res_tfound ? type_value_d : '0;
		end
	end

endmodule

@@ rtl/dol_checker.sv @@
// ----------------------------------------------------------------------------
// dol_checker
// Port-level checks for the DHCP option locator, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dol_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input dol_pkg::dol_out_t out_data
);
	import dol_pkg::*;

	// A stalled result stays in place until its transfer.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// A bad cookie drops everything the walk found.
	`ASSERT_IMP(a_bad_cookie, clk, arst_n, out_valid && !out_data.cookie_valid, !out_data.option_found && !out_data.type_found, "found flag set with bad cookie")

	// Offset and length read zero when the option was not found.
	`ASSERT_IMP(a_not_found, clk, arst_n, out_valid && !out_data.option_found, out_data.value_offset == '0 && out_data.value_length == '0, "nonzero option fields when not found")

	// A found value starts past the cookie, code and length bytes.
	`ASSERT_IMP(a_min_offset, clk, arst_n, out_valid && out_data.option_found, out_data.value_offset >= OFFSET_W'(MIN_VALUE_OFFSET), "value offset inside the cookie")

	// Message type reads zero when no type option was seen.
	`ASSERT_IMP(a_no_type, clk, arst_n, out_valid && !out_data.type_found, out_data.message_type == '0, "message type set when not found")

endmodule

bind dhcp_option_locator dol_checker u_dol_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
